/* hdl/hex_lagrange_basis_eval_assert.svh */
// Assertion macros shared by the RTL of the Lagrange basis evaluator.
`ifndef HEX_LAGRANGE_BASIS_EVAL_ASSERT_SVH
`define HEX_LAGRANGE_BASIS_EVAL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HLBE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HLBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/hlbe_pkg.sv */
`timescale 1ns / 1ps

package hlbe_pkg;

   // Field widths of the item and result channels.
   localparam int NODE_W  = 5;
   localparam int COORD_W = 15;
   localparam int VALUE_W = 16;
   localparam int GRAD_W  = 18;
   localparam int ORDER_W = 2;

   // Basis order codes.
   localparam logic [ORDER_W-1:0] ORDER_LINEAR = 2'd1;
   localparam logic [ORDER_W-1:0] ORDER_QUAD   = 2'd2;

   // Node counts per order.
   localparam int LINEAR_NODES = 8;
   localparam int QUAD_NODES   = 27;

   // One-dimensional node position along an axis.
   typedef logic [1:0] axis_sel_type;

   localparam axis_sel_type K_LO = 2'd0;
   localparam axis_sel_type K_MI = 2'd1;
   localparam axis_sel_type K_HI = 2'd2;

   typedef struct packed {
      axis_sel_type kz;
      axis_sel_type ky;
      axis_sel_type kx;
   } node_axes_type;

   function automatic node_axes_type axes(input axis_sel_type x, input axis_sel_type y,
                                          input axis_sel_type z);
      node_axes_type a;
      a.kx = x;
      a.ky = y;
      a.kz = z;
      return a;
   endfunction

   // Per-axis positions of the 27 triquadratic nodes. Corners use only the low and
   // high positions, which also serve the trilinear basis.
   function automatic node_axes_type node_axes(input logic [NODE_W-1:0] node);
      node_axes_type a;
      case (node)
         5'd0:    a = axes(K_LO, K_LO, K_LO);
         5'd1:    a = axes(K_HI, K_LO, K_LO);
         5'd2:    a = axes(K_HI, K_HI, K_LO);
         5'd3:    a = axes(K_LO, K_HI, K_LO);
         5'd4:    a = axes(K_LO, K_LO, K_HI);
         5'd5:    a = axes(K_HI, K_LO, K_HI);
         5'd6:    a = axes(K_HI, K_HI, K_HI);
         5'd7:    a = axes(K_LO, K_HI, K_HI);
         5'd8:    a = axes(K_MI, K_LO, K_LO);
         5'd9:    a = axes(K_HI, K_MI, K_LO);
         5'd10:   a = axes(K_MI, K_HI, K_LO);
         5'd11:   a = axes(K_LO, K_MI, K_LO);
         5'd12:   a = axes(K_LO, K_LO, K_MI);
         5'd13:   a = axes(K_HI, K_LO, K_MI);
         5'd14:   a = axes(K_HI, K_HI, K_MI);
         5'd15:   a = axes(K_LO, K_HI, K_MI);
         5'd16:   a = axes(K_MI, K_LO, K_HI);
         5'd17:   a = axes(K_HI, K_MI, K_HI);
         5'd18:   a = axes(K_MI, K_HI, K_HI);
         5'd19:   a = axes(K_LO, K_MI, K_HI);
         5'd20:   a = axes(K_LO, K_MI, K_MI);
         5'd21:   a = axes(K_HI, K_MI, K_MI);
         5'd22:   a = axes(K_MI, K_LO, K_MI);
         5'd23:   a = axes(K_MI, K_HI, K_MI);
         5'd24:   a = axes(K_MI, K_MI, K_LO);
         5'd25:   a = axes(K_MI, K_MI, K_HI);
         5'd26:   a = axes(K_MI, K_MI, K_MI);
         default: a = axes(K_LO, K_LO, K_LO);
      endcase
      return a;
   endfunction

endpackage

/* hdl/hlbe_req_if.sv */
`timescale 1ns / 1ps

interface hlbe_req_if;
   logic                              valid;
   logic                              ready;
   logic [hlbe_pkg::NODE_W-1:0]       node_index;
   logic [hlbe_pkg::COORD_W-1:0]      coord_x;
   logic [hlbe_pkg::COORD_W-1:0]      coord_y;
   logic [hlbe_pkg::COORD_W-1:0]      coord_z;

   modport source (output valid, node_index, coord_x, coord_y, coord_z, input ready);
   modport sink (input valid, node_index, coord_x, coord_y, coord_z, output ready);
endinterface

/* hdl/hlbe_rsp_if.sv */
`timescale 1ns / 1ps

interface hlbe_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [hlbe_pkg::VALUE_W-1:0] shape_value;
   logic signed [hlbe_pkg::GRAD_W-1:0]  grad_x;
   logic signed [hlbe_pkg::GRAD_W-1:0]  grad_y;
   logic signed [hlbe_pkg::GRAD_W-1:0]  grad_z;
   logic                                bad_index;

   modport source (output valid, shape_value, grad_x, grad_y, grad_z, bad_index,
                   input ready);
   modport sink (input valid, shape_value, grad_x, grad_y, grad_z, bad_index,
                 output ready);
endinterface

/* hdl/hex_lagrange_basis_eval.sv */
`timescale 1ns / 1ps
`include "hex_lagrange_basis_eval_assert.svh"

// Channel   Direction  Carries
// req_ch    in         node_index, coord_x, coord_y, coord_z
// rsp_ch    out        shape_value, grad_x, grad_y, grad_z, bad_index
// csr_*     in         basis_order (write only)
//
// Six register stages: decode and clip, 1D multiply, 1D rounding, pair products,
// z products, result register. One item enters per cycle unless the result register stalls.
// The throughput is set by the pipeline, with one multiplier per product at each stage.
// Reset sets basis_order to the triquadratic basis and empties the pipeline.
// When a result waits untaken in the result register, every stage holds and req_ch
// deasserts ready; nothing is dropped or repeated.
module hex_lagrange_basis_eval #(
   parameter int FRAC_BITS = 14
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [hlbe_pkg::ORDER_W-1:0]   csr_wr_data,
   hlbe_req_if.sink                       req_ch,
   hlbe_rsp_if.source                     rsp_ch
);

   localparam int TW = FRAC_BITS + 1;
   localparam int CW = (TW > hlbe_pkg::COORD_W) ? TW : hlbe_pkg::COORD_W;
   localparam int FW = FRAC_BITS + 4;
   localparam int STAGES = 6;

   localparam logic [CW-1:0] ONE_C = CW'(1 << FRAC_BITS);
   localparam logic [TW-1:0] ONE_T = TW'(1 << FRAC_BITS);

   // Basis order register.
   logic [hlbe_pkg::ORDER_W-1:0] order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= hlbe_pkg::ORDER_QUAD;
      end else if (csr_wr_en) begin
         order_ff <= csr_wr_data;
      end
   end

   // Pipeline control: every stage moves when the result register is empty or its result is taken.
   logic              adv;
   logic [STAGES-1:0] vld_in, vld_ff;

   assign adv          = !vld_ff[STAGES-1] || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign vld_in       = {vld_ff[STAGES-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: clip coordinates, look up node positions, check the index.
   logic [hlbe_pkg::COORD_W-1:0] coord [3];
   logic [CW-1:0]                cext  [3];
   logic [TW-1:0]                t_in  [3];
   logic [TW-1:0]                t_ff  [3];
   hlbe_pkg::axis_sel_type       k_in  [3];
   hlbe_pkg::axis_sel_type       k_ff  [3];
   hlbe_pkg::node_axes_type      ax;
   logic                         bad_in;
   logic                         bad1_ff, bad2_ff, bad3_ff;
   logic [hlbe_pkg::ORDER_W-1:0] ord_ff;

   assign coord[0] = req_ch.coord_x;
   assign coord[1] = req_ch.coord_y;
   assign coord[2] = req_ch.coord_z;
   assign ax       = hlbe_pkg::node_axes(req_ch.node_index);
   assign k_in[0]  = ax.kx;
   assign k_in[1]  = ax.ky;
   assign k_in[2]  = ax.kz;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         cext[a] = CW'(coord[a]);
         t_in[a] = (cext[a] > ONE_C) ? ONE_T : cext[a][TW-1:0];
      end
      unique case (order_ff)
         hlbe_pkg::ORDER_LINEAR:
            bad_in = (req_ch.node_index >= hlbe_pkg::NODE_W'(hlbe_pkg::LINEAR_NODES));
         hlbe_pkg::ORDER_QUAD:
            bad_in = (req_ch.node_index >= hlbe_pkg::NODE_W'(hlbe_pkg::QUAD_NODES));
         default:
            bad_in = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            t_ff[a] <= t_in[a];
            k_ff[a] <= k_in[a];
         end
         ord_ff  <= order_ff;
         bad1_ff <= bad_in;
         bad2_ff <= bad1_ff;
         bad3_ff <= bad2_ff;
      end
   end

   // Stages 2 and 3: one 1D unit per axis.
   logic signed [FW-1:0] f_ax [3];
   logic signed [FW-1:0] d_ax [3];

   for (genvar a = 0; a < 3; a++) begin : g_axis
      hlbe_axis #(
         .FRAC_BITS (FRAC_BITS)
      ) u_axis (
         .clock (clock),
         .adv   (adv),
         .t     (t_ff[a]),
         .k     (k_ff[a]),
         .quad  (ord_ff == hlbe_pkg::ORDER_QUAD),
         .f     (f_ax[a]),
         .d     (d_ax[a])
      );
   end

   // Stages 4 to 6: products and the result register.
   hlbe_prod #(
      .FRAC_BITS (FRAC_BITS)
   ) u_prod (
      .clock       (clock),
      .adv         (adv),
      .f0          (f_ax[0]),
      .d0          (d_ax[0]),
      .f1          (f_ax[1]),
      .d1          (d_ax[1]),
      .f2          (f_ax[2]),
      .d2          (d_ax[2]),
      .bad         (bad3_ff),
      .shape_value (rsp_ch.shape_value),
      .grad_x      (rsp_ch.grad_x),
      .grad_y      (rsp_ch.grad_y),
      .grad_z      (rsp_ch.grad_z),
      .bad_index   (rsp_ch.bad_index)
   );

   assign rsp_ch.valid = vld_ff[STAGES-1];

   // A flagged result carries zeros in every numeric field.
   `HLBE_ASSERT_IMPL(a_bad_zero, clock, reset, rsp_ch.valid && rsp_ch.bad_index, rsp_ch.shape_value == '0 && rsp_ch.grad_x == '0 && rsp_ch.grad_y == '0 && rsp_ch.grad_z == '0, "flagged result has nonzero fields")
   // A stalled pipeline keeps all its valid bits.
   `HLBE_ASSERT_NEXT(a_stall_hold, clock, reset, !adv, $stable(vld_ff), "pipeline moved during a stall")
   // An order without meaning flags every item.
   `HLBE_ASSERT_IMPL(a_order_bad, clock, reset, vld_ff[0] && ord_ff != hlbe_pkg::ORDER_LINEAR && ord_ff != hlbe_pkg::ORDER_QUAD, bad1_ff, "item not flagged under an undefined order")

endmodule

/* hdl/hlbe_axis.sv */
`timescale 1ns / 1ps

// One-dimensional Lagrange polynomial and derivative for one axis, two stages.
module hlbe_axis #(
   parameter int FRAC_BITS = 14
) (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [FRAC_BITS:0]            t,
   input  hlbe_pkg::axis_sel_type        k,
   input  logic                          quad,
   output logic signed [FRAC_BITS+3:0]   f,
   output logic signed [FRAC_BITS+3:0]   d
);

   localparam int OW = FRAC_BITS + 3;
   localparam int PW = 2 * OW;
   localparam int FW = FRAC_BITS + 4;

   localparam logic signed [OW-1:0] ONE_OP = OW'(1 << FRAC_BITS);
   localparam logic signed [FW-1:0] ONE_F   = FW'(1 << FRAC_BITS);
   localparam logic signed [FW-1:0] THREE_F = FW'(3 << FRAC_BITS);
   localparam logic signed [FW-1:0] FOUR_F  = FW'(4 << FRAC_BITS);
   localparam logic signed [PW-1:0] HALF_P  = PW'(1 << (FRAC_BITS - 1));

   logic signed [OW-1:0] ts;
   logic signed [FW-1:0] tf;
   logic signed [OW-1:0] opa;
   logic signed [OW-1:0] opb;
   logic signed [PW-1:0] prod_in, prod_ff;
   logic signed [FW-1:0] dq;
   logic signed [FW-1:0] d_in, d_ff;
   logic signed [FW-1:0] lin_in, lin_ff;
   logic                 mid_ff;
   logic                 quad_ff;
   logic signed [PW-1:0] scaled;
   logic signed [PW-1:0] rounded;
   logic signed [FW-1:0] f_in, f_ff;
   logic signed [FW-1:0] d3_ff;

   assign ts = signed'({2'b00, t});
   assign tf = FW'(ts);

   // Stage 2: one multiply selects its operands from the axis position.
   always_comb begin
      opa = (k == hlbe_pkg::K_LO) ? ONE_OP - ts : ts;
      case (k)
         hlbe_pkg::K_LO: opb = ONE_OP - (ts <<< 1);
         hlbe_pkg::K_MI: opb = ONE_OP - ts;
         default:        opb = (ts <<< 1) - ONE_OP;
      endcase
      prod_in = opa * opb;
   end

   // Exact derivatives and the linear polynomial.
   always_comb begin
      case (k)
         hlbe_pkg::K_LO: dq = (tf <<< 2) - THREE_F;
         hlbe_pkg::K_MI: dq = FOUR_F - (tf <<< 3);
         default:        dq = (tf <<< 2) - ONE_F;
      endcase
      if (quad) begin
         d_in = dq;
      end else begin
         d_in = (k == hlbe_pkg::K_LO) ? -ONE_F : ONE_F;
      end
      lin_in = (k == hlbe_pkg::K_LO) ? ONE_F - tf : tf;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         d_ff    <= d_in;
         lin_ff  <= lin_in;
         mid_ff  <= (k == hlbe_pkg::K_MI);
         quad_ff <= quad;
      end
   end

   // Stage 3: scale the middle polynomial by four and round half up.
   always_comb begin
      scaled  = mid_ff ? (prod_ff <<< 2) : prod_ff;
      rounded = scaled + HALF_P;
      f_in    = quad_ff ? signed'(rounded[FRAC_BITS+FW-1:FRAC_BITS]) : lin_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_ff  <= f_in;
         d3_ff <= d_ff;
      end
   end

   assign f = f_ff;
   assign d = d3_ff;

endmodule

/* hdl/hlbe_prod.sv */
`timescale 1ns / 1ps

// Three-way products of the 1D factors, rounding, saturation and the result register.
module hlbe_prod #(
   parameter int FRAC_BITS = 14
) (
   input  logic                                clock,
   input  logic                                adv,
   input  logic signed [FRAC_BITS+3:0]         f0,
   input  logic signed [FRAC_BITS+3:0]         d0,
   input  logic signed [FRAC_BITS+3:0]         f1,
   input  logic signed [FRAC_BITS+3:0]         d1,
   input  logic signed [FRAC_BITS+3:0]         f2,
   input  logic signed [FRAC_BITS+3:0]         d2,
   input  logic                                bad,
   output logic signed [hlbe_pkg::VALUE_W-1:0] shape_value,
   output logic signed [hlbe_pkg::GRAD_W-1:0]  grad_x,
   output logic signed [hlbe_pkg::GRAD_W-1:0]  grad_y,
   output logic signed [hlbe_pkg::GRAD_W-1:0]  grad_z,
   output logic                                bad_index
);

   localparam int FW = FRAC_BITS + 4;
   localparam int P2 = 2 * FW;
   localparam int RW = FRAC_BITS + 5;
   localparam int MW = RW + FW;
   localparam int QW = MW - FRAC_BITS;

   localparam logic signed [P2-1:0] HALF_2 = P2'(1 << (FRAC_BITS - 1));
   localparam logic signed [MW-1:0] HALF_M = MW'(1 << (FRAC_BITS - 1));

   // Clip to the signed range of a w-bit field.
   function automatic logic signed [QW-1:0] sat_to(input logic signed [QW-1:0] v,
                                                   input int w);
      logic signed [QW-1:0] hi;
      logic signed [QW-1:0] lo;
      hi = QW'((64'sd1 <<< (w - 1)) - 64'sd1);
      lo = -hi - QW'(1);
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   logic signed [P2-1:0] ff01_ff, df01_ff, fd01_ff;
   logic signed [FW-1:0] f2_ff, d2_ff;
   logic                 bad4_ff;

   // Stage 4: pair products of the x and y factors.
   always_ff @(posedge clock) begin
      if (adv) begin
         ff01_ff <= f0 * f1;
         df01_ff <= d0 * f1;
         fd01_ff <= f0 * d1;
         f2_ff   <= f2;
         d2_ff   <= d2;
         bad4_ff <= bad;
      end
   end

   logic signed [P2-1:0] r_ff01, r_df01, r_fd01;
   logic signed [RW-1:0] ff01_rnd, df01_rnd, fd01_rnd;
   logic signed [MW-1:0] mval_in, mval_ff;
   logic signed [MW-1:0] mgx_in, mgx_ff;
   logic signed [MW-1:0] mgy_in, mgy_ff;
   logic signed [MW-1:0] mgz_in, mgz_ff;
   logic                 bad5_ff;

   // Stage 5: round the pair products and multiply by the z factor.
   always_comb begin
      r_ff01   = ff01_ff + HALF_2;
      r_df01   = df01_ff + HALF_2;
      r_fd01   = fd01_ff + HALF_2;
      ff01_rnd = signed'(r_ff01[FRAC_BITS+RW-1:FRAC_BITS]);
      df01_rnd = signed'(r_df01[FRAC_BITS+RW-1:FRAC_BITS]);
      fd01_rnd = signed'(r_fd01[FRAC_BITS+RW-1:FRAC_BITS]);
      mval_in  = ff01_rnd * f2_ff;
      mgx_in   = df01_rnd * f2_ff;
      mgy_in   = fd01_rnd * f2_ff;
      mgz_in   = ff01_rnd * d2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mval_ff <= mval_in;
         mgx_ff  <= mgx_in;
         mgy_ff  <= mgy_in;
         mgz_ff  <= mgz_in;
         bad5_ff <= bad4_ff;
      end
   end

   logic signed [MW-1:0] r_val, r_gx, r_gy, r_gz;
   logic signed [QW-1:0] s_val, s_gx, s_gy, s_gz;
   logic signed [hlbe_pkg::VALUE_W-1:0] val_in, val_ff;
   logic signed [hlbe_pkg::GRAD_W-1:0]  gx_in, gx_ff;
   logic signed [hlbe_pkg::GRAD_W-1:0]  gy_in, gy_ff;
   logic signed [hlbe_pkg::GRAD_W-1:0]  gz_in, gz_ff;
   logic                                bad6_ff;

   // Stage 6: final rounding, saturation, and zeros for a node that does not exist.
   always_comb begin
      r_val = mval_ff + HALF_M;
      r_gx  = mgx_ff + HALF_M;
      r_gy  = mgy_ff + HALF_M;
      r_gz  = mgz_ff + HALF_M;
      s_val = sat_to(signed'(r_val[MW-1:FRAC_BITS]), hlbe_pkg::VALUE_W);
      s_gx  = sat_to(signed'(r_gx[MW-1:FRAC_BITS]), hlbe_pkg::GRAD_W);
      s_gy  = sat_to(signed'(r_gy[MW-1:FRAC_BITS]), hlbe_pkg::GRAD_W);
      s_gz  = sat_to(signed'(r_gz[MW-1:FRAC_BITS]), hlbe_pkg::GRAD_W);
      if (bad5_ff) begin
         val_in = '0;
         gx_in  = '0;
         gy_in  = '0;
         gz_in  = '0;
      end else begin
         val_in = s_val[hlbe_pkg::VALUE_W-1:0];
         gx_in  = s_gx[hlbe_pkg::GRAD_W-1:0];
         gy_in  = s_gy[hlbe_pkg::GRAD_W-1:0];
         gz_in  = s_gz[hlbe_pkg::GRAD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         val_ff  <= val_in;
         gx_ff   <= gx_in;
         gy_ff   <= gy_in;
         gz_ff   <= gz_in;
         bad6_ff <= bad5_ff;
      end
   end

   assign shape_value = val_ff;
   assign grad_x      = gx_ff;
   assign grad_y      = gy_ff;
   assign grad_z      = gz_ff;
   assign bad_index   = bad6_ff;

endmodule

/* tb/sv/hex_lagrange_basis_eval_tb.sv */
`timescale 1ns / 1ps

module hex_lagrange_basis_eval_tb;
   import hlbe_pkg::*;

   localparam int FRAC_Q = 14;
   localparam longint ONE_Q = longint'(1) << FRAC_Q;
   localparam longint HALF_Q = longint'(1) << (FRAC_Q - 1);
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 20;
   localparam int LONG_HOLD = 200;
   localparam int HOLD_AFTER = 150;
   localparam int MAX_REPORTS = 10;

   // Register settings that select no basis at all.
   localparam logic [ORDER_W-1:0] ORDER_NONE_LO = 2'd0;
   localparam logic [ORDER_W-1:0] ORDER_NONE_HI = 2'd3;

   // Coordinate landmarks in unsigned Q14.
   localparam logic [COORD_W-1:0] COORD_ZERO = 15'd0;
   localparam logic [COORD_W-1:0] COORD_HALF = 15'd8192;
   localparam logic [COORD_W-1:0] COORD_ONE  = 15'd16384;
   localparam logic [COORD_W-1:0] COORD_MAX  = 15'd32767;

   typedef struct packed {
      logic [NODE_W-1:0]  node;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
   } eval_point_t;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic signed [GRAD_W-1:0]  gx;
      logic signed [GRAD_W-1:0]  gy;
      logic signed [GRAD_W-1:0]  gz;
      logic                      bad;
   } basis_result_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en;
   logic [ORDER_W-1:0] csr_wr_data;

   hlbe_req_if req_ch ();
   hlbe_rsp_if rsp_ch ();

   hex_lagrange_basis_eval #(
      .FRAC_BITS(FRAC_Q)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch)
   );

   eval_point_t        pending_points [$];
   basis_result_t      expected_results [$];
   logic [ORDER_W-1:0] order_model;
   eval_point_t        next_point;
   eval_point_t        taken_point;
   basis_result_t      want_result;
   basis_result_t      got_result;
   int                 points_queued = 0;
   int                 points_taken = 0;
   int                 results_seen = 0;
   int                 mismatches = 0;
   logic               item_taken = 1'b0;
   int                 tx_gap = 0;
   int                 rx_gap = 0;
   bit                 tx_steady = 1'b0;
   bit                 rx_steady = 1'b0;
   int                 hold_left = 0;
   bit                 hold_done = 1'b0;
   int                 cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Axis positions of a node, packed as {x, y, z}.
   function automatic logic [5:0] node_position(input logic [NODE_W-1:0] node);
      case (node)
         5'd0:    return {K_LO, K_LO, K_LO};
         5'd1:    return {K_HI, K_LO, K_LO};
         5'd2:    return {K_HI, K_HI, K_LO};
         5'd3:    return {K_LO, K_HI, K_LO};
         5'd4:    return {K_LO, K_LO, K_HI};
         5'd5:    return {K_HI, K_LO, K_HI};
         5'd6:    return {K_HI, K_HI, K_HI};
         5'd7:    return {K_LO, K_HI, K_HI};
         5'd8:    return {K_MI, K_LO, K_LO};
         5'd9:    return {K_HI, K_MI, K_LO};
         5'd10:   return {K_MI, K_HI, K_LO};
         5'd11:   return {K_LO, K_MI, K_LO};
         5'd12:   return {K_LO, K_LO, K_MI};
         5'd13:   return {K_HI, K_LO, K_MI};
         5'd14:   return {K_HI, K_HI, K_MI};
         5'd15:   return {K_LO, K_HI, K_MI};
         5'd16:   return {K_MI, K_LO, K_HI};
         5'd17:   return {K_HI, K_MI, K_HI};
         5'd18:   return {K_MI, K_HI, K_HI};
         5'd19:   return {K_LO, K_MI, K_HI};
         5'd20:   return {K_LO, K_MI, K_MI};
         5'd21:   return {K_HI, K_MI, K_MI};
         5'd22:   return {K_MI, K_LO, K_MI};
         5'd23:   return {K_MI, K_HI, K_MI};
         5'd24:   return {K_MI, K_MI, K_LO};
         5'd25:   return {K_MI, K_MI, K_HI};
         default: return {K_MI, K_MI, K_MI};
      endcase
   endfunction

   // Round half up: the arithmetic shift of a signed value floors.
   function automatic longint round_q(input longint p);
      return (p + HALF_Q) >>> FRAC_Q;
   endfunction

   function automatic longint clamp_field(input longint v, input int width);
      longint hi;
      hi = (longint'(1) <<< (width - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   // Shape function of one node and its gradient at one point, for one order.
   function automatic basis_result_t eval_basis(input logic [ORDER_W-1:0] order,
                                                input eval_point_t pt);
      basis_result_t res;
      logic [5:0]    pos;
      axis_sel_type  k;
      longint        t;
      longint        f [3];
      longint        d [3];
      int            count;
      res = '0;
      count = (order == ORDER_LINEAR) ? LINEAR_NODES :
              (order == ORDER_QUAD) ? QUAD_NODES : 0;
      if (int'(pt.node) >= count) begin
         res.bad = 1'b1;
         return res;
      end
      pos = node_position(pt.node);
      for (int a = 0; a < 3; a++) begin
         case (a)
            0: begin
               t = pt.x;
               k = pos[5:4];
            end
            1: begin
               t = pt.y;
               k = pos[3:2];
            end
            default: begin
               t = pt.z;
               k = pos[1:0];
            end
         endcase
         if (t > ONE_Q) t = ONE_Q;
         // The trilinear basis uses only the corner positions of the table.
         if (order == ORDER_LINEAR) begin
            if (k == K_LO) begin
               f[a] = ONE_Q - t;
               d[a] = -ONE_Q;
            end else begin
               f[a] = t;
               d[a] = ONE_Q;
            end
         end else if (k == K_LO) begin
            f[a] = round_q((ONE_Q - t) * (ONE_Q - 2 * t));
            d[a] = 4 * t - 3 * ONE_Q;
         end else if (k == K_MI) begin
            f[a] = round_q(4 * t * (ONE_Q - t));
            d[a] = 4 * ONE_Q - 8 * t;
         end else begin
            f[a] = round_q(t * (2 * t - ONE_Q));
            d[a] = 4 * t - ONE_Q;
         end
      end
      res.value = VALUE_W'(clamp_field(round_q(round_q(f[0] * f[1]) * f[2]), VALUE_W));
      res.gx = GRAD_W'(clamp_field(round_q(round_q(d[0] * f[1]) * f[2]), GRAD_W));
      res.gy = GRAD_W'(clamp_field(round_q(round_q(f[0] * d[1]) * f[2]), GRAD_W));
      res.gz = GRAD_W'(clamp_field(round_q(round_q(f[0] * f[1]) * d[2]), GRAD_W));
      return res;
   endfunction

   // Idle stretches are mostly short, now and then long.
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [COORD_W-1:0] pick_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return COORD_W'($urandom_range(0, 16384));
      if (r == 7) begin
         case ($urandom_range(0, 2))
            0:       return COORD_ZERO;
            1:       return COORD_HALF;
            default: return COORD_ONE;
         endcase
      end
      if (r == 8) return COORD_W'($urandom_range(16385, 32767));
      return COORD_W'($urandom_range(0, 32767));
   endfunction

   // Mostly nodes of the current order, the rest, and all under an undefined order, anywhere in the field.
   function automatic logic [NODE_W-1:0] pick_node(input logic [ORDER_W-1:0] order);
      int count;
      count = (order == ORDER_LINEAR) ? LINEAR_NODES :
              (order == ORDER_QUAD) ? QUAD_NODES : 0;
      if (count == 0 || $urandom_range(0, 6) == 0) return NODE_W'($urandom_range(0, 31));
      return NODE_W'($urandom_range(0, count - 1));
   endfunction

   task automatic queue_point(input logic [NODE_W-1:0] node, input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
      eval_point_t pt;
      pt.node = node;
      pt.x = x;
      pt.y = y;
      pt.z = z;
      pending_points = {pending_points, pt};
      points_queued++;
   endtask

   task automatic queue_random_points(input int n);
      repeat (n) begin
         queue_point(pick_node(order_model), pick_coord(), pick_coord(), pick_coord());
      end
   endtask

   // Returns at a falling edge once every item is taken and every result checked.
   task automatic wait_idle();
      do @(negedge clock);
      while (points_taken != points_queued || expected_results.size() != 0);
   endtask

   task automatic write_order(input logic [ORDER_W-1:0] value);
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      order_model = value;
   endtask

   // Stimulus sequence: one phase per basis order setting, then a second triquadratic phase.
   initial begin
      req_ch.valid = 1'b0;
      req_ch.node_index = '0;
      req_ch.coord_x = '0;
      req_ch.coord_y = '0;
      req_ch.coord_z = '0;
      rsp_ch.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      order_model = ORDER_QUAD;
      repeat (6) @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      // Triquadratic basis out of reset: corners, the center, clipping, bad indexes.
      queue_point(5'd0, COORD_ZERO, COORD_ZERO, COORD_ZERO);
      queue_point(5'd6, COORD_ONE, COORD_ONE, COORD_ONE);
      queue_point(5'd26, COORD_HALF, COORD_HALF, COORD_HALF);
      queue_point(5'd26, COORD_MAX, COORD_MAX, COORD_MAX);
      queue_point(5'd13, 15'd16385, COORD_ZERO, COORD_HALF);
      queue_point(5'd24, 15'd4096, 15'd12288, 15'd1);
      queue_point(5'd1, 15'd16383, 15'd1, COORD_ONE);
      queue_point(5'd17, 15'd2731, 15'd5461, 15'd13653);
      queue_point(5'd27, COORD_HALF, COORD_HALF, COORD_HALF);
      queue_point(5'd31, COORD_MAX, COORD_MAX, COORD_MAX);
      queue_random_points(420);
      wait_idle();

      // Trilinear basis.
      write_order(ORDER_LINEAR);
      @(posedge clock);
      queue_point(5'd0, COORD_ZERO, COORD_ZERO, COORD_ZERO);
      queue_point(5'd7, COORD_ONE, COORD_ONE, COORD_ONE);
      queue_point(5'd8, COORD_HALF, COORD_HALF, COORD_HALF);
      queue_point(5'd3, COORD_MAX, COORD_ZERO, COORD_HALF);
      queue_point(5'd5, COORD_HALF, COORD_HALF, COORD_HALF);
      queue_random_points(260);
      wait_idle();

      // Both settings without a basis flag every node.
      write_order(ORDER_NONE_LO);
      @(posedge clock);
      queue_point(5'd0, COORD_ZERO, COORD_ZERO, COORD_ZERO);
      queue_point(5'd26, COORD_ONE, COORD_ONE, COORD_ONE);
      queue_random_points(40);
      wait_idle();

      write_order(ORDER_NONE_HI);
      @(posedge clock);
      queue_point(5'd0, COORD_HALF, COORD_HALF, COORD_HALF);
      queue_point(5'd7, COORD_ONE, COORD_ZERO, COORD_ONE);
      queue_random_points(40);
      wait_idle();

      // Back to the triquadratic basis.
      write_order(ORDER_QUAD);
      @(posedge clock);
      queue_random_points(240);
      wait_idle();

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("hex_lagrange_basis_eval regression: pass");
      end else begin
         $display("hex_lagrange_basis_eval regression: fail");
      end
      $finish;
   end

   // Record each accepted item and predict its result.
   always @(posedge clock) begin
      item_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready) begin
         taken_point = '{node: req_ch.node_index, x: req_ch.coord_x,
                         y: req_ch.coord_y, z: req_ch.coord_z};
         expected_results = {expected_results, eval_basis(order_model, taken_point)};
         points_taken <= points_taken + 1;
      end
   end

   // Offer the next item once the current one is gone, with random gaps between.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || item_taken) begin
         if ($urandom_range(0, 63) == 0) tx_steady = !tx_steady;
         if (tx_gap > 0) begin
            req_ch.valid <= 1'b0;
            tx_gap = tx_gap - 1;
         end else if (pending_points.size() != 0) begin
            next_point = pending_points.pop_front();
            req_ch.node_index <= next_point.node;
            req_ch.coord_x <= next_point.x;
            req_ch.coord_y <= next_point.y;
            req_ch.coord_z <= next_point.z;
            req_ch.valid <= 1'b1;
            tx_gap = tx_steady ? 0 : idle_span();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // One long hold-off of the result side, so that the pipeline fills and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end
   end

   // Result side ready, with random stalls and stretches without any.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
         rsp_ch.ready <= 1'b0;
         rx_gap = rx_gap - 1;
      end else begin
         if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
         rsp_ch.ready <= 1'b1;
         rx_gap = rx_steady ? 0 : idle_span();
      end
   end

   // Compare each accepted result with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen <= results_seen + 1;
         got_result = '{value: rsp_ch.shape_value, gx: rsp_ch.grad_x, gy: rsp_ch.grad_y,
                        gz: rsp_ch.grad_z, bad: rsp_ch.bad_index};
         if (expected_results.size() == 0) begin
            if (mismatches < MAX_REPORTS) begin
               $display("result %0d arrived with nothing expected: value %0d bad %0b",
                        results_seen, got_result.value, got_result.bad);
            end
            mismatches = mismatches + 1;
         end else begin
            want_result = expected_results.pop_front();
            if (got_result !== want_result) begin
               if (mismatches < MAX_REPORTS) begin
                  $display("result %0d mismatch: expected value %0d grad %0d %0d %0d bad %0b",
                           results_seen, want_result.value, want_result.gx, want_result.gy,
                           want_result.gz, want_result.bad);
                  $display("   got value %0d grad %0d %0d %0d bad %0b",
                           got_result.value, got_result.gx, got_result.gy, got_result.gz,
                           got_result.bad);
               end
               mismatches = mismatches + 1;
            end
         end
      end
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("hex_lagrange_basis_eval regression: fail");
         $finish;
      end
   end

endmodule

/* files.f */
+incdir+hdl
hdl/hlbe_pkg.sv
hdl/hlbe_req_if.sv
hdl/hlbe_rsp_if.sv
hdl/hlbe_axis.sv
hdl/hlbe_prod.sv
hdl/hex_lagrange_basis_eval.sv
tb/sv/hex_lagrange_basis_eval_tb.sv
